FILE: rtl/step_sequencer_swing_skip_loop_macros.svh
// ----------------------------------------------------------------------------
// Step sequencer assertion macros
// Shared property shorthands for the sequencer's checker.
// ----------------------------------------------------------------------------
`ifndef STEP_SEQUENCER_SWING_SKIP_LOOP_MACROS_SVH
`define STEP_SEQUENCER_SWING_SKIP_LOOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, held off during reset.
`define SSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, held off during reset.
`define SSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ssl_pkg.sv
// ----------------------------------------------------------------------------
// Step sequencer package
// Types, codes, reset constants and step table lookups for the sequencer.
// ----------------------------------------------------------------------------
package ssl_pkg;

    localparam int STEPS_DEF      = 16;
    localparam int MAX_VOICES_DEF = 16;
    localparam int COUNT_BITS_DEF = 24;

    localparam logic [23:0] SPB_RESET     = 24'd22050;
    localparam logic [7:0]  SHUFFLE_RESET = 8'd128;
    localparam logic [4:0]  VOICE_RESET   = 5'd16;
    localparam logic [8:0]  Q_ONE         = 9'd256;
    localparam logic [33:0] ROUND_HALF    = 34'd128;
    localparam int          HW_VOICES     = 16;

    localparam logic [1:0] MODE_SKIP = 2'd1;
    localparam logic [1:0] MODE_LOOP = 2'd2;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_STOP  = 2'd1,
        REQ_PAUSE = 2'd2,
        REQ_PLAY  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        RM_STOP  = 2'd0,
        RM_PAUSE = 2'd1,
        RM_PLAY  = 2'd2
    } run_mode_t;

    typedef enum logic [2:0] {
        CFG_STEP_MODES   = 3'd0,
        CFG_PROB_LO      = 3'd1,
        CFG_PROB_HI      = 3'd2,
        CFG_SPB          = 3'd3,
        CFG_SHUFFLE      = 3'd4,
        CFG_VOICE_COUNT  = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_VOICE,
        ST_COMMIT
    } seq_state_t;

    typedef struct packed {
        req_t       req_type;
        logic [7:0] random_draw;
    } ssl_in_t;

    typedef struct packed {
        logic [3:0] step_index;
        logic       note_fires;
        logic [3:0] release_voice;
        logic [3:0] play_voice;
    } ssl_out_t;

    // Two mode bits per step; steps 16 and up read as normal.
    function automatic logic [1:0] mode_of(input logic [31:0] modes, input logic [4:0] s);
        logic [1:0] m;
        m = s[4] ? 2'd0 : modes[{s[3:0], 1'b0} +: 2];
        return m;
    endfunction

    // One probability byte per step; steps 16 and up read as zero.
    function automatic logic [7:0] prob_of(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [4:0] s);
        logic [7:0] p;
        if (s[4]) begin
            p = 8'd0;
        end else if (s[3]) begin
            p = hi[{s[2:0], 3'b000} +: 8];
        end else begin
            p = lo[{s[2:0], 3'b000} +: 8];
        end
        return p;
    endfunction

endpackage

FILE: rtl/ssl_reload_unit.sv
// ----------------------------------------------------------------------------
// Swing countdown reload unit
// Scales samples_per_beat by the swing fraction, rounds half up, saturates.
// ----------------------------------------------------------------------------
module ssl_reload_unit import ssl_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  load,
    input  logic                  odd_half,
    input  logic [7:0]            shuffle,
    input  logic [23:0]           samples_per_beat,
    output logic [COUNT_BITS-1:0] reload
);

    localparam int EXT_W = (COUNT_BITS > 26) ? COUNT_BITS + 1 : 27;

    logic [8:0]       frac;
    logic [32:0]      prod_next;
    logic [32:0]      prod_reg;
    logic [33:0]      rounded;
    logic [EXT_W-1:0] scaled;
    logic [EXT_W-1:0] cap;

    // Odd half takes shuffle, even half takes one minus shuffle.
    assign frac      = odd_half ? {1'b0, shuffle} : (Q_ONE - {1'b0, shuffle});
    assign prod_next = 33'(samples_per_beat) * 33'(frac);

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign rounded = 34'(prod_reg) + ROUND_HALF;
    assign scaled  = EXT_W'(rounded[33:8]);
    assign cap     = EXT_W'({COUNT_BITS{1'b1}});
    assign reload  = (scaled > cap) ? {COUNT_BITS{1'b1}} : scaled[COUNT_BITS-1:0];

endmodule

FILE: rtl/step_sequencer_swing_skip_loop.sv
// ----------------------------------------------------------------------------
// Step sequencer with swing, skip and loop steps
// One beat per audio sample; emits a step event when a step is entered.
// ----------------------------------------------------------------------------
// Timing: a beat that does not advance the step (stop, pause, play, or a tick
// that finds the countdown running or the sequencer not playing) is taken and
// the block is ready again in the next cycle. A tick that advances the step
// passes through the search, multiply, voice and commit states before the
// block is ready again. The search walks past 0 to STEPS skip steps, one step
// per cycle through a single step incrementer, and the round-robin voice wrap
// needs 0 to 8 subtractions in a single voice subtractor. One result beat is
// held in an output register, so the block takes new beats while a result
// waits; it only stalls in the commit state of an advance if the previous
// result has not been taken yet. Configuration writes land in one cycle and
// must be made while the block is idle.
// ----------------------------------------------------------------------------
module step_sequencer_swing_skip_loop import ssl_pkg::*; #(
    parameter int STEPS      = STEPS_DEF,
    parameter int MAX_VOICES = MAX_VOICES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // request beats
    input  logic        s_valid,
    output logic        s_ready,
    input  ssl_in_t     s_data,
    // step event beats
    output logic        m_valid,
    input  logic        m_ready,
    output ssl_out_t    m_data
);

    localparam int STEP_W    = $clog2(STEPS);
    localparam int TRY_W     = $clog2(STEPS + 1);
    localparam int VOICE_CAP = (MAX_VOICES < HW_VOICES) ? MAX_VOICES : HW_VOICES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] step_modes_reg;
    logic [63:0] prob_lo_reg;
    logic [63:0] prob_hi_reg;
    logic [23:0] spb_reg;
    logic [7:0]  shuffle_reg;
    logic [4:0]  voice_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_modes_reg  <= '0;
            prob_lo_reg     <= '0;
            prob_hi_reg     <= '0;
            spb_reg         <= SPB_RESET;
            shuffle_reg     <= SHUFFLE_RESET;
            voice_count_reg <= VOICE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_MODES:  step_modes_reg  <= cfg_wdata[31:0];
                CFG_PROB_LO:     prob_lo_reg     <= cfg_wdata;
                CFG_PROB_HI:     prob_hi_reg     <= cfg_wdata;
                CFG_SPB:         spb_reg         <= cfg_wdata[23:0];
                CFG_SHUFFLE:     shuffle_reg     <= cfg_wdata[7:0];
                CFG_VOICE_COUNT: voice_count_reg <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequence state and sequencer working registers
    // ------------------------------------------------------------------
    seq_state_t            state_reg, state_next;
    logic [STEP_W-1:0]     pos_reg, pos_next;
    logic                  first_reg, first_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  odd_reg, odd_next;
    logic [3:0]            voice_reg, voice_next;
    run_mode_t             run_reg, run_next;

    logic [STEP_W-1:0]     cand_reg, cand_next;    // step under test
    logic [TRY_W-1:0]      tries_reg, tries_next;
    logic [7:0]            draw_reg, draw_next;
    logic                  fires_reg, fires_next;
    logic [4:0]            vtmp_reg, vtmp_next;    // voice wrap remainder

    logic                  out_valid_reg, out_valid_next;
    ssl_out_t              out_reg, out_next;

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------
    logic [4:0]            voices;
    logic                  rotate;
    logic [STEP_W-1:0]     first_cand;
    logic [STEP_W-1:0]     step_cand;
    logic [STEP_W-1:0]     inc_in;
    logic [STEP_W-1:0]     inc_out;
    logic                  skip_more;
    logic                  mul_load;
    logic [COUNT_BITS-1:0] reload;
    logic                  accept;
    logic                  out_free;

    // Limit the voice count to what the design holds.
    assign voices = (voice_count_reg > 5'(VOICE_CAP)) ? 5'(VOICE_CAP) : voice_count_reg;
    assign rotate = fires_reg && (voices > 5'd1);

    // Single step incrementer with wrap at STEPS, shared by entry and search.
    assign inc_in  = (state_reg == ST_SEARCH) ? cand_reg : pos_reg;
    assign inc_out = (inc_in == STEP_W'(STEPS - 1)) ? '0 : inc_in + 1'b1;

    // First candidate: step 0 before the first step, else the next step.
    // A loop step sends the sequence back to step 0.
    always_comb begin
        first_cand = first_reg ? '0 : inc_out;
        if (mode_of(step_modes_reg, 5'(first_cand)) == MODE_LOOP) begin
            first_cand = '0;
        end
        step_cand = inc_out;
        if (mode_of(step_modes_reg, 5'(inc_out)) == MODE_LOOP) begin
            step_cand = '0;
        end
    end

    // Keep walking while on a skip step, short of a full lap.
    assign skip_more = (mode_of(step_modes_reg, 5'(cand_reg)) == MODE_SKIP)
                       && (first_reg || (cand_reg != pos_reg))
                       && (tries_reg < TRY_W'(STEPS));

    ssl_reload_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_reload (
        .aclk             (aclk),
        .load             (mul_load),
        .odd_half         (odd_reg),
        .shuffle          (shuffle_reg),
        .samples_per_beat (spb_reg),
        .reload           (reload)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        odd_next       = odd_reg;
        voice_next     = voice_reg;
        run_next       = run_reg;
        cand_next      = cand_reg;
        tries_next     = tries_reg;
        draw_next      = draw_reg;
        fires_next     = fires_reg;
        vtmp_next      = vtmp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        mul_load       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.req_type)
                        REQ_STOP: begin
                            // Clear the sequence as at reset; registers stay.
                            pos_next   = '0;
                            first_next = 1'b1;
                            count_next = '0;
                            odd_next   = 1'b0;
                            voice_next = '0;
                            run_next   = RM_STOP;
                        end
                        REQ_PAUSE: run_next = RM_PAUSE;
                        REQ_PLAY:  run_next = RM_PLAY;
                        REQ_TICK: begin
                            if ((count_reg == '0) && (run_reg == RM_PLAY)) begin
                                // Countdown expired: start the step search.
                                cand_next  = first_cand;
                                tries_next = '0;
                                draw_next  = s_data.random_draw;
                                state_next = ST_SEARCH;
                            end else if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                if (skip_more) begin
                    cand_next  = step_cand;
                    tries_next = tries_reg + 1'b1;
                end else begin
                    state_next = ST_MUL;
                end
            end

            ST_MUL: begin
                // Product goes into the reload unit; decide the note meanwhile.
                mul_load   = 1'b1;
                fires_next = draw_reg < prob_of(prob_lo_reg, prob_hi_reg, 5'(cand_reg));
                vtmp_next  = {1'b0, voice_reg};
                if ((draw_reg < prob_of(prob_lo_reg, prob_hi_reg, 5'(cand_reg)))
                    && (voices > 5'd1)) begin
                    vtmp_next = {1'b0, voice_reg} + 5'd1;
                end
                state_next = ST_VOICE;
            end

            ST_VOICE: begin
                // Wrap the next voice by repeated subtraction.
                if (rotate && (vtmp_reg >= voices)) begin
                    vtmp_next = vtmp_reg - voices;
                end else begin
                    state_next = ST_COMMIT;
                end
            end

            ST_COMMIT: begin
                if (out_free) begin
                    out_next.step_index    = 4'(cand_reg);
                    out_next.note_fires    = fires_reg;
                    out_next.release_voice = voice_reg;
                    out_next.play_voice    = fires_reg ? vtmp_reg[3:0] : 4'd0;
                    out_valid_next         = 1'b1;
                    pos_next               = cand_reg;
                    first_next             = 1'b0;
                    odd_next               = !odd_reg;
                    // Reload, then count this sample as well.
                    count_next             = (reload != '0) ? reload - 1'b1 : reload;
                    if (fires_reg) begin
                        voice_next = vtmp_reg[3:0];
                    end
                    state_next             = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            first_reg     <= 1'b1;
            count_reg     <= '0;
            odd_reg       <= 1'b0;
            voice_reg     <= '0;
            run_reg       <= RM_STOP;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
            odd_reg       <= odd_next;
            voice_reg     <= voice_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge aclk) begin
        cand_reg  <= cand_next;
        tries_reg <= tries_next;
        draw_reg  <= draw_next;
        fires_reg <= fires_next;
        vtmp_reg  <= vtmp_next;
        out_reg   <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/ssl_checker.sv
// ----------------------------------------------------------------------------
// Step sequencer port checker
// Watches the sequencer's ports and flags handshake and event slips.
// ----------------------------------------------------------------------------
`include "step_sequencer_swing_skip_loop_macros.svh"

module ssl_checker import ssl_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input ssl_in_t     s_data,
    input logic        m_valid,
    input logic        m_ready,
    input ssl_out_t    m_data
);

    logic out_stall;
    logic ctrl_beat;
    logic silent_beat;

    assign out_stall   = m_valid && !m_ready;
    assign ctrl_beat   = s_valid && s_ready && (s_data.req_type != REQ_TICK);
    assign silent_beat = m_valid && !m_data.note_fires;

    // A stalled result beat holds.
    `SSL_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(m_data), "stalled result changed")

    // Control requests leave the sequencer ready again in the next cycle.
    `SSL_ASSERT_NEXT(a_ctrl_fast, ctrl_beat, s_ready, "control request held the sequencer busy")

    // No note, no play voice.
    `SSL_ASSERT_NOW(a_play_zero, silent_beat, m_data.play_voice == 4'd0, "play voice with no note")

    // A new result only comes out of a busy sequencer.
    `SSL_ASSERT_NOW(a_out_origin, $rose(m_valid), !$past(s_ready), "result appeared while idle")

endmodule

bind step_sequencer_swing_skip_loop ssl_checker u_ssl_checker (.*);

FILE: dv/step_sequencer_swing_skip_loop_tb.sv
// ----------------------------------------------------------------------------
// Step sequencer with swing, skip and loop steps: self-checking testbench
// Sends sample ticks and transport requests under random idling on both
// sides, predicts every step event in a scoreboard and compares each
// returned beat field by field. The step table, swing and voice settings
// are rewritten between phases.
// ----------------------------------------------------------------------------
module step_sequencer_swing_skip_loop_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssl_pkg::*;

    localparam int STEP_COUNT     = STEPS_DEF;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 48;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 6;
    localparam int PHASE_BEATS    = 96;
    localparam int IDLE_PERCENT   = 12;

    // ------------------------------------------------------------------------
    // Step event scoreboard: mirrors the sequencer and queues its events
    // ------------------------------------------------------------------------
    class step_scoreboard;
        logic [31:0] step_modes;
        logic [63:0] prob_lo;
        logic [63:0] prob_hi;
        logic [23:0] spb;
        logic [7:0]  shuffle;
        logic [4:0]  voice_count;

        logic [3:0]  position;
        bit          awaiting_first;
        logic [23:0] countdown;
        bit          odd_half;
        logic [3:0]  voice;
        run_mode_t   run;

        ssl_out_t    pending_events[$];
        int          errors;
        int          n_requests;
        int          n_events;
        int          n_notes;

        function new();
            step_modes  = '0;
            prob_lo     = '0;
            prob_hi     = '0;
            spb         = SPB_RESET;
            shuffle     = SHUFFLE_RESET;
            voice_count = VOICE_RESET;
            errors      = 0;
            n_requests  = 0;
            n_events    = 0;
            n_notes     = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            position       = '0;
            awaiting_first = 1'b1;
            countdown      = '0;
            odd_half       = 1'b0;
            voice          = '0;
            run            = RM_STOP;
        endfunction

        function void load_register(cfg_reg_t idx, logic [63:0] value);
            case (idx)
                CFG_STEP_MODES:  step_modes  = value[31:0];
                CFG_PROB_LO:     prob_lo     = value;
                CFG_PROB_HI:     prob_hi     = value;
                CFG_SPB:         spb         = value[23:0];
                CFG_SHUFFLE:     shuffle     = value[7:0];
                CFG_VOICE_COUNT: voice_count = value[4:0];
                default: ;
            endcase
        endfunction

        function logic [1:0] step_mode(int s);
            return step_modes[2*s +: 2];
        endfunction

        function logic [7:0] step_prob(int s);
            if (s < 8) return prob_lo[8*s +: 8];
            return prob_hi[8*(s-8) +: 8];
        endfunction

        // Advance the mirror by one accepted request beat.
        function void note_request(ssl_in_t beat);
            int          cur;
            int          nxt;
            int          tries;
            int          voices;
            logic [8:0]  frac;
            logic [63:0] reload;
            ssl_out_t    ev;
            n_requests++;
            case (beat.req_type)
                REQ_STOP: begin
                    clear_sequence();
                    return;
                end
                REQ_PAUSE: begin
                    run = RM_PAUSE;
                    return;
                end
                REQ_PLAY: begin
                    run = RM_PLAY;
                    return;
                end
                default: ;
            endcase

            if (countdown == '0 && run == RM_PLAY) begin
                // Search for the next step; a first step starts the walk at 0.
                cur = position;
                nxt = awaiting_first ? 0 : (cur + 1) % STEP_COUNT;
                if (step_mode(nxt) == MODE_LOOP) nxt = 0;
                tries = 0;
                while (step_mode(nxt) == MODE_SKIP && (awaiting_first || nxt != cur)
                       && tries < STEP_COUNT) begin
                    nxt = (nxt + 1) % STEP_COUNT;
                    if (step_mode(nxt) == MODE_LOOP) nxt = 0;
                    tries++;
                end
                position       = nxt[3:0];
                awaiting_first = 1'b0;

                // Swing: odd halves get shuffle, even halves one minus shuffle.
                frac   = odd_half ? {1'b0, shuffle} : Q_ONE - {1'b0, shuffle};
                reload = ({40'd0, spb} * {55'd0, frac} + 64'd128) >> 8;
                if (reload > 64'hFF_FFFF) reload = 64'hFF_FFFF;
                countdown = reload[23:0];
                odd_half  = !odd_half;

                ev.step_index    = nxt[3:0];
                ev.release_voice = voice;
                ev.note_fires    = beat.random_draw < step_prob(nxt);
                ev.play_voice    = '0;
                if (ev.note_fires) begin
                    voices = voice_count;
                    if (voices > MAX_VOICES_DEF) voices = MAX_VOICES_DEF;
                    if (voices > HW_VOICES) voices = HW_VOICES;
                    if (voices > 1) voice = (voice + 1) % voices;
                    ev.play_voice = voice;
                    n_notes++;
                end
                pending_events.push_back(ev);
                n_events++;
            end

            if (countdown != '0) countdown--;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_event(ssl_out_t got);
            ssl_out_t want;
            if (pending_events.size() == 0) begin
                errors++;
                $display("%0t: step event mismatch, expected none, actual step %0d note %0d",
                         $time, got.step_index, got.note_fires);
                return;
            end
            want = pending_events.pop_front();
            compare_field("step_index", want.step_index, got.step_index);
            compare_field("note_fires", want.note_fires, got.note_fires);
            compare_field("release_voice", want.release_voice, got.release_voice);
            compare_field("play_voice", want.play_voice, got.play_voice);
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and clocking
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    ssl_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    ssl_out_t    m_data;

    step_sequencer_swing_skip_loop dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    step_scoreboard sb = new();

    bit calm;          // no idling on either side while set
    bit stall_ask;     // sender asks the receiver for one long hold-off
    int settings_used;

    initial aclk = 1'b0;
    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Monitors: every beat is sampled at the edge that moves it
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_request(s_data);
        if (aresetn && m_valid && m_ready) sb.check_event(m_data);
    end

    // Watchdog: end the run once nothing has moved for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("Watchdog expired with %0d step events outstanding", sb.outstanding());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        bit stall_done;
        stall_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_ask && !stall_done) begin
                // Hold ready low so the output register fills and input stalls.
                stall_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one request beat; hold it until the block takes it.
    task automatic offer(input req_t req, input logic [7:0] draw);
        ssl_in_t beat;
        beat.req_type    = req;
        beat.random_draw = draw;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait for every predicted event, then let the block go idle.
    task automatic drain();
        s_valid <= 1'b0;
        calm    <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_register(input cfg_reg_t idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.load_register(idx, value);
    endtask

    // Rewrite the whole register set; only call with the block idle.
    task automatic apply_settings(input logic [31:0] modes, input logic [63:0] plo,
                                  input logic [63:0] phi, input logic [23:0] spb,
                                  input logic [7:0] shf, input logic [4:0] vc);
        load_register(CFG_STEP_MODES, {32'd0, modes});
        load_register(CFG_PROB_LO, plo);
        load_register(CFG_PROB_HI, phi);
        load_register(CFG_SPB, {40'd0, spb});
        load_register(CFG_SHUFFLE, {56'd0, shf});
        load_register(CFG_VOICE_COUNT, {59'd0, vc});
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Mostly ticks while playing, with transport requests mixed in.
    task automatic offer_random();
        int   pick;
        req_t req;
        pick = $urandom_range(99);
        if (pick < 78)      req = REQ_TICK;
        else if (pick < 86) req = REQ_PLAY;
        else if (pick < 93) req = REQ_PAUSE;
        else                req = REQ_STOP;
        offer(req, 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] modes;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_STEP_MODES;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_data        <= '0;
        calm          <= 1'b0;
        stall_ask     <= 1'b0;
        settings_used = 1;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: a paused tick does nothing, the first played tick
        // enters step 0 with zero probability, then the long countdown runs.
        offer(REQ_PAUSE, 8'd0);
        offer(REQ_TICK, 8'd0);
        offer(REQ_PLAY, 8'd0);
        offer(REQ_TICK, 8'd0);
        offer(REQ_TICK, 8'd255);
        offer(REQ_STOP, 8'd0);
        drain();

        // Every step skips: the search wraps right round and lands where it
        // started. Zero countdown makes every tick advance.
        apply_settings(32'h5555_5555, 64'hFFFF_FFFF_FFFF_FFFF, 64'hC8C8_C8C8_C8C8_C8C8,
                       24'd0, 8'd0, 5'd1);
        offer(REQ_PLAY, 8'd0);
        offer(REQ_TICK, 8'd0);
        offer(REQ_TICK, 8'd254);
        offer(REQ_TICK, 8'd255);
        offer(REQ_STOP, 8'd0);
        drain();

        // Skip at step 1, mode 3 at step 2, loop at step 3, skip at step 15;
        // draws straddle the strict probability compare, voice count zero.
        apply_settings(32'h4000_00B4, 64'h0000_0000_00C8_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                       24'd1, 8'd26, 5'd0);
        offer(REQ_PLAY, 8'd0);
        offer(REQ_TICK, 8'd0);
        offer(REQ_TICK, 8'd199);
        offer(REQ_TICK, 8'd200);
        offer(REQ_TICK, 8'd200);
        offer(REQ_TICK, 8'd0);
        offer(REQ_TICK, 8'd199);
        offer(REQ_TICK, 8'd255);
        offer(REQ_STOP, 8'd0);
        drain();

        // Every step loops, longest beat, a swing of 230, voice count above range.
        apply_settings(32'hAAAA_AAAA, 64'h0102_0408_1020_4080, 64'd0,
                       24'hFF_FFFF, 8'd230, 5'd31);
        offer(REQ_PLAY, 8'd0);
        offer(REQ_TICK, 8'd127);
        offer(REQ_TICK, 8'd0);
        offer(REQ_STOP, 8'd0);
        drain();

        // Random phases: fresh settings each, short beats so steps advance.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 3)
                0:       modes = $urandom;
                1:       modes = $urandom & 32'h5555_5555;
                default: modes = $urandom & $urandom;
            endcase
            apply_settings(modes, {$urandom, $urandom}, {$urandom, $urandom},
                           (ph == PHASES - 1) ? 24'($urandom_range(9, 40))
                                              : 24'($urandom_range(0, 6)),
                           8'($urandom_range(255)),
                           ph[0] ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16)));
            if (ph == 2) calm <= 1'b1;
            offer(REQ_PLAY, 8'($urandom_range(255)));
            for (int n = 1; n < PHASE_BEATS; n++) begin
                if (ph == 1 && n == 20) stall_ask <= 1'b1;
                offer_random();
            end
            drain();
        end

        $display("Sent %0d request beats over %0d register settings", sb.n_requests,
                 settings_used);
        $display("Checked %0d step events, %0d of them firing a note", sb.n_events,
                 sb.n_notes);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
